[rtl/core/wpb_pkg.sv]
// wpb_pkg: constants, payload types and the peak function of the waveform peak binner
// no dependencies; used by waveform_peak_binner_top
package wpb_pkg;

    localparam int BINS            = 4096;
    localparam int SAMPLES_PER_BIN = 512;
    localparam int PEAK_SHIFT      = 7;
    localparam int BIN_W           = $clog2(BINS);
    localparam int OFS_W           = $clog2(SAMPLES_PER_BIN);
    localparam int WIDTH_W         = 11;
    localparam int PEAK_W          = 8;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd480;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] sample;
        logic [11:0]        playhead_bin;
        logic [9:0]         pixel;
    } t_in;

    typedef struct packed {
        logic [11:0] bin_index;
        logic [7:0]  bin_peak;
    } t_out;

    // magnitude with the most negative code taken as 32767, then shifted down
    function automatic logic [PEAK_W-1:0] sample_peak(input logic signed [15:0] s);
        logic [15:0] mag;
        begin
            if (s[15]) begin
                mag = 16'(~s) + 16'd1;
                if (mag[15]) begin
                    mag = 16'h7FFF;
                end
            end else begin
                mag = s;
            end
            sample_peak = mag[PEAK_SHIFT +: PEAK_W];
        end
    endfunction

endpackage

[rtl/core/waveform_peak_binner_top.sv]
// waveform_peak_binner_top: peak envelope store with a read-modify-write pipeline
// depends on wpb_pkg (types, constants, sample_peak)
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | wpb_pkg::t_in
//  out     | output    | o_out_valid / i_out_ready   | wpb_pkg::t_out
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | window_width, 11 bits
//
// one beat per cycle sustained while the output is not stalled; each beat is first read from
// memory into the read stage, then modified, written back and placed in the output register
// reset: no clearing pass; a bin not yet written since reset reads as zero, judged from
// the write position and a wrap flag, so beats are taken from the first cycle
// a stalled output holds the pipeline; a same-bin write back is forwarded to the next beat
module waveform_peak_binner_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wpb_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wpb_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wpb_pkg::WIDTH_W-1:0]         i_cfg_data
);

    logic [wpb_pkg::PEAK_W-1:0] mem [wpb_pkg::BINS];

    logic [wpb_pkg::WIDTH_W-1:0] r_width;
    logic [wpb_pkg::BIN_W-1:0]   r_bin_cnt;
    logic [wpb_pkg::OFS_W-1:0]   r_ofs_cnt;
    logic                        r_wrapped;

    logic                        r_s1_valid;
    logic                        r_s1_cmd;
    logic [wpb_pkg::BIN_W-1:0]   r_s1_bin;
    logic [wpb_pkg::PEAK_W-1:0]  r_s1_pk;
    logic                        r_s1_first;
    logic                        r_s1_entry;
    logic                        r_s1_fwd;
    logic [wpb_pkg::PEAK_W-1:0]  r_fwd_data;
    logic [wpb_pkg::PEAK_W-1:0]  r_rd_data;

    logic                        r_out_valid;
    wpb_pkg::t_out               r_out;

    logic                        in_fire;
    logic                        s1_move;
    logic                        out_free;
    logic [wpb_pkg::BIN_W-1:0]   n_bin;
    logic [wpb_pkg::BIN_W+1:0]   rd_sum;
    logic [wpb_pkg::BIN_W-1:0]   rd_bin;
    logic                        n_entry;
    logic [wpb_pkg::PEAK_W-1:0]  old_pk;
    logic [wpb_pkg::PEAK_W-1:0]  new_pk;
    logic                        wr_en;

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_move     = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // read address: playhead - half width + pixel, mod BINS
    always_comb begin
        rd_sum = (wpb_pkg::BIN_W+2)'(i_in.playhead_bin)
               + (wpb_pkg::BIN_W+2)'(wpb_pkg::BINS)
               - (wpb_pkg::BIN_W+2)'(r_width[wpb_pkg::WIDTH_W-1:1])
               + (wpb_pkg::BIN_W+2)'(i_in.pixel);
        if (rd_sum >= (wpb_pkg::BIN_W+2)'(wpb_pkg::BINS)) begin
            rd_sum = rd_sum - (wpb_pkg::BIN_W+2)'(wpb_pkg::BINS);
        end
        if (rd_sum >= (wpb_pkg::BIN_W+2)'(wpb_pkg::BINS)) begin
            rd_sum = rd_sum - (wpb_pkg::BIN_W+2)'(wpb_pkg::BINS);
        end
        rd_bin = rd_sum[wpb_pkg::BIN_W-1:0];
        n_bin  = (i_in.cmd == wpb_pkg::CMD_READ) ? rd_bin : r_bin_cnt;
        n_entry = r_wrapped || (n_bin < r_bin_cnt)
                || ((n_bin == r_bin_cnt) && (r_ofs_cnt != '0));
    end

    always_comb begin
        if (r_s1_fwd) begin
            old_pk = r_fwd_data;
        end else if (r_s1_entry) begin
            old_pk = r_rd_data;
        end else begin
            old_pk = '0;
        end
        new_pk = (r_s1_first || (r_s1_pk > old_pk)) ? r_s1_pk : old_pk;
        wr_en  = s1_move && (r_s1_cmd == wpb_pkg::CMD_PUSH);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_bin] <= new_pk;
        end
        if (in_fire) begin
            r_rd_data <= mem[n_bin];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= wpb_pkg::WIDTH_RESET;
            r_bin_cnt <= '0;
            r_ofs_cnt <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            if (in_fire && (i_in.cmd == wpb_pkg::CMD_PUSH)) begin
                if (r_ofs_cnt == wpb_pkg::OFS_W'(wpb_pkg::SAMPLES_PER_BIN - 1)) begin
                    r_ofs_cnt <= '0;
                    if (r_bin_cnt == wpb_pkg::BIN_W'(wpb_pkg::BINS - 1)) begin
                        r_bin_cnt <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_bin_cnt <= r_bin_cnt + 1'b1;
                    end
                end else begin
                    r_ofs_cnt <= r_ofs_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd   <= i_in.cmd;
            r_s1_bin   <= n_bin;
            r_s1_pk    <= wpb_pkg::sample_peak(i_in.sample);
            r_s1_first <= (r_ofs_cnt == '0);
            r_s1_entry <= n_entry;
            r_s1_fwd   <= wr_en && (r_s1_bin == n_bin);
            r_fwd_data <= new_pk;
        end
        if (s1_move) begin
            r_out.bin_index <= 12'(r_s1_bin);
            r_out.bin_peak  <= (r_s1_cmd == wpb_pkg::CMD_PUSH) ? new_pk : old_pk;
        end
    end

    a_ready_low_means_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && o_out_valid && !i_out_ready))
        else $error("input held off without an output stall");

    a_beat_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted beat missing from read stage");

    a_stage_drains_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> o_out_valid)
        else $error("result lost between stage and output register");

    a_fwd_only_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && wr_en && (r_s1_bin == n_bin)) |=> r_s1_fwd)
        else $error("same-bin write back not forwarded");

endmodule
